FILE: hw/rtl/pal_pkg.sv
// Shared types and constants of the positional array list.
`default_nettype none
package pal_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 2;
	localparam int POS_W    = 5;
	localparam int CNTP_W   = 5;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QFILL_W  = $clog2(QDEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         pos;
		status_t                  status;
		logic [CNT_W-1:0]         cnt_after;
	} job_t;

	typedef struct packed {
		logic                     strobe;
		status_t                  status;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         cnt;
		logic                     last;
	} res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/positional_array_list.sv
// Top level of the positional array list: front, job queue and back end.
//
//   channel   direction  handshake             fields
//   command   in         start && !busy        command, data, position
//   result    out        done (one cycle)      status, value, count, last
//
// An accepted item enters the job queue at its edge; the back end works it once
// it reaches the queue head, and the result shows on the ports in the cycle after.
// Append, insert and remove need no sequencing in the back end: the cell
// chain shifts all entries at once. A dump reads one stored element per cycle,
// set by the single read port of the cell chain, and gives one result on an empty list.
// busy rises only while the two-entry queue is full, i.e. behind a long dump.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset clears the count, queue and sequencer; cell contents stay undefined.
`default_nettype none
module positional_array_list (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          command,
	input  wire logic signed [31:0]  data,
	input  wire logic [4:0]          position,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [31:0]       value,
	output logic [4:0]               count,
	output logic                     last
);
	import pal_pkg::*;

	logic accept;
	job_t front_job;
	job_t head_job;
	logic head_valid;
	logic q_full;
	logic pop;
	res_t res;

	// Take a command whenever the queue has room.
	assign busy   = q_full;
	assign accept = start && !busy;

	pal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.data     (data),
		.position (position),
		.job      (front_job)
	);

	pal_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (front_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.full       (q_full)
	);

	pal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.res        (res)
	);

	// Drive the result ports straight from the back-end result register.
	assign done   = res.strobe;
	assign status = res.status;
	assign value  = res.value;
	assign count  = CNTP_W'(res.cnt);
	assign last   = res.last;

	// A result that is not the last of its item is always a dump element.
	a_notlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> status == ST_OK)
		else $error("non-final result without ok status");

	// Dump elements stream without gaps and keep the count.
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && count == $past(count))
		else $error("dump stream broke or count changed");

	// A failed command leaves the value at zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> value == '0 && last)
		else $error("failed command result carries data");

	// The queue never loses an item: busy only while the back end holds a job.
	a_busy_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> head_valid)
		else $error("busy without a pending job");

endmodule
`default_nettype wire

FILE: hw/rtl/pal_front.sv
// Front end: accept commands, track the count and classify each item into a job.
`default_nettype none
module pal_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [pal_pkg::CMD_W-1:0]        command,
	input  wire logic signed [pal_pkg::DATA_W-1:0] data,
	input  wire logic [pal_pkg::POS_W-1:0]        position,
	output pal_pkg::job_t                         job
);
	import pal_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;

	assign full  = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign pos_w = CMP_W'(position);
	assign cnt_w = CMP_W'(cnt_q);

	always_comb begin
		job.op        = OP_NONE;
		job.data      = data;
		job.pos       = IDX_W'(position);
		job.status    = ST_OK;
		job.cnt_after = cnt_q;
		unique case (cmd_t'(command))
			CMD_APPEND: begin
				if (full) begin
					job.status = ST_FULL;
				end else begin
					job.op        = OP_INSERT;
					job.pos       = IDX_W'(cnt_q);
					job.cnt_after = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					job.status = ST_FULL;
				end else if (pos_w > cnt_w) begin
					job.status = ST_BADPOS;
				end else begin
					job.op        = OP_INSERT;
					job.cnt_after = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					job.status = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					job.status = ST_BADPOS;
				end else begin
					job.op        = OP_REMOVE;
					job.cnt_after = CNT_W'(cnt_q - 1'b1);
				end
			end
			CMD_DUMP: begin
				if (empty) begin
					job.status = ST_EMPTY;
				end else begin
					job.op = OP_DUMP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= job.cnt_after;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pal_fifo.sv
// Short job queue between front and back.
`default_nettype none
module pal_fifo (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire pal_pkg::job_t push_job,
	input  wire logic    pop,
	output logic         head_valid,
	output pal_pkg::job_t head_job,
	output logic         full
);
	import pal_pkg::*;

	job_t                entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QFILL_W-1:0]  fill_q;
	logic                do_pop;

	assign head_valid = (fill_q != '0);
	assign full       = (fill_q == QFILL_W'(QDEPTH));
	assign head_job   = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				fill_q <= QFILL_W'(fill_q + 1'b1);
			end else if (!push && do_pop) begin
				fill_q <= QFILL_W'(fill_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pal_back.sv
// Back end: cell chain that shifts on insert and remove, dump sequencer, result register.
`default_nettype none
module pal_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     head_valid,
	input  wire pal_pkg::job_t head_job,
	output logic          pop,
	output pal_pkg::res_t res
);
	import pal_pkg::*;

	logic signed [DATA_W-1:0] cells_q [CAPACITY];
	logic signed [DATA_W-1:0] cells_d [CAPACITY];
	logic [IDX_W-1:0]         idx_q;
	logic                     is_dump;
	logic                     dump_last;
	res_t                     res_q;

	assign is_dump   = (head_job.op == OP_DUMP);
	assign dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == head_job.cnt_after);
	assign pop       = head_valid && (!is_dump || dump_last);
	assign res       = res_q;

	// Every cell picks its own next value: hold, take the neighbor, or take the new word.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_d[i] = cells_q[i];
		end
		if (head_valid && head_job.op == OP_INSERT) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDX_W'(i) == head_job.pos) begin
					cells_d[i] = head_job.data;
				end else if (i > 0 && IDX_W'(i) > head_job.pos) begin
					cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (head_valid && head_job.op == OP_REMOVE) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IDX_W'(i) >= head_job.pos) begin
					cells_d[i] = cells_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			res_q <= '0;
		end else begin
			res_q.strobe <= head_valid;
			if (head_valid && is_dump) begin
				idx_q <= dump_last ? '0 : IDX_W'(idx_q + 1'b1);
			end
			if (head_valid) begin
				res_q.status <= head_job.status;
				res_q.value  <= is_dump ? cells_q[idx_q] : '0;
				res_q.cnt    <= head_job.cnt_after;
				res_q.last   <= !is_dump || dump_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_q[i] <= cells_d[i];
		end
	end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench of the positional array list.
`default_nettype none
module tb_top;
	import pal_pkg::*;

	// Queue entry of one expected result item.
	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic [4:0]         count;
		logic               last;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic signed [31:0] data;
	logic [4:0]         position;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] value;
	logic [4:0]         count;
	logic               last;

	// Shadow copy of the stored words, lowest position first.
	logic signed [31:0] shadow_list[$];
	// Results predicted but not yet seen on the ports, oldest first.
	list_result_t       expected_results[$];

	int fail_count = 0;
	// Sender pacing: items left in the current burst, and whether gaps are on.
	int burst_left = 0;
	bit idle_on    = 1'b1;

	positional_array_list uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.data     (data),
		.position (position),
		.done     (done),
		.status   (status),
		.value    (value),
		.count    (count),
		.last     (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// Queue one expected result.
	task automatic push_result(input status_t st, input logic signed [31:0] val,
			input logic [4:0] cnt, input logic lst);
		list_result_t r;
		r.status = st;
		r.value  = val;
		r.count  = cnt;
		r.last   = lst;
		expected_results.push_back(r);
	endtask

	// Apply one accepted command to the shadow list and queue what it yields.
	task automatic predict_list_results(input cmd_t cmd, input logic signed [31:0] word,
			input logic [4:0] pos);
		int      n;
		status_t st;
		n  = shadow_list.size();
		st = ST_OK;
		case (cmd)
			CMD_DUMP: begin
				// An empty list answers once with status empty; otherwise
				// every word comes out in order, last flag on the final one.
				if (n == 0) begin
					push_result(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						push_result(ST_OK, shadow_list[i], n[4:0], i == n - 1);
				end
				return;
			end
			CMD_APPEND: begin
				if (n >= CAPACITY) st = ST_FULL;
				else shadow_list.push_back(word);
			end
			CMD_INSERT: begin
				// A full list is refused before the position is looked at.
				if (n >= CAPACITY) st = ST_FULL;
				else if (pos > n) st = ST_BADPOS;
				else shadow_list.insert(pos, word);
			end
			default: begin
				// Empty wins over a bad position on remove.
				if (n == 0) st = ST_EMPTY;
				else if (pos >= n) st = ST_BADPOS;
				else shadow_list.delete(pos);
			end
		endcase
		push_result(st, '0, 5'(shadow_list.size()), 1'b1);
	endtask

	// Send one item: insert a random gap between bursts, hold the item until
	// the block takes it, then record what it should produce.
	task automatic send_item(input cmd_t cmd, input logic signed [31:0] word,
			input logic [4:0] pos);
		int gap;
		if (idle_on && burst_left == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		start    <= 1'b1;
		command  <= cmd;
		data     <= word;
		position <= pos;
		// busy read right after the edge is the value the edge saw.
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_list_results(cmd, word, pos);
	endtask

	// Compare every result item against the oldest expectation.
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), '0);
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch("status", 32'(status), 32'(exp_r.status));
				if (value !== exp_r.value)
					report_mismatch("value", value, exp_r.value);
				if (count !== exp_r.count)
					report_mismatch("count", 32'(count), 32'(exp_r.count));
				if (last !== exp_r.last)
					report_mismatch("last", 32'(last), 32'(exp_r.last));
			end
		end
	end

	// Commands on an empty list: dump, remove and insert past the end.
	task automatic test_empty_list;
		send_item(CMD_DUMP, 32'sd0, 5'd0);
		send_item(CMD_REMOVE, 32'sd0, 5'd31);
		send_item(CMD_REMOVE, 32'sd0, 5'd0);
		send_item(CMD_INSERT, 32'sd5, 5'd1);
	endtask

	// Position rules for insert and remove, with extreme data words.
	task automatic test_positions;
		send_item(CMD_INSERT, 32'sh7fffffff, 5'd0);
		send_item(CMD_APPEND, 32'sh80000000, 5'd0);
		// Insert at the count behaves as append.
		send_item(CMD_INSERT, -32'sd1, 5'd2);
		send_item(CMD_INSERT, 32'sd1, 5'd4);
		send_item(CMD_INSERT, 32'sd0, 5'd1);
		send_item(CMD_REMOVE, 32'sd0, 5'd4);
		send_item(CMD_REMOVE, 32'sd0, 5'd31);
		send_item(CMD_REMOVE, 32'sd0, 5'd1);
		send_item(CMD_DUMP, 32'sd0, 5'd0);
	endtask

	// Fill to capacity, check the full refusals, dump, then drain a little.
	task automatic test_full_list;
		int n;
		while (shadow_list.size() < CAPACITY) begin
			n = shadow_list.size();
			if (n % 2)
				send_item(CMD_INSERT, $urandom, 5'($urandom_range(0, n)));
			else
				send_item(CMD_APPEND, $urandom, 5'd0);
		end
		send_item(CMD_APPEND, 32'sd7, 5'd0);
		// Full wins over a bad position on insert.
		send_item(CMD_INSERT, 32'sd7, 5'd31);
		send_item(CMD_DUMP, 32'sd0, 5'd0);
		send_item(CMD_REMOVE, 32'sd0, 5'd15);
		send_item(CMD_REMOVE, 32'sd0, 5'd0);
		send_item(CMD_DUMP, 32'sd0, 5'd0);
	endtask

	// Random traffic that sweeps the list between empty and full.
	task automatic test_random_traffic;
		cmd_t               cmd;
		logic signed [31:0] word;
		logic [4:0]         pos;
		int                 r;
		int                 n;
		bit                 growing;
		growing = 1'b1;
		for (int k = 0; k < 160; k++) begin
			n = shadow_list.size();
			// Turn the sweep around at the ends, and now and then in between.
			if (n >= CAPACITY) growing = 1'b0;
			else if (n == 0) growing = 1'b1;
			else if ($urandom_range(0, 19) == 0) growing = !growing;
			// Run a stretch with no gaps in the middle of the traffic.
			idle_on = !(k >= 60 && k < 100);
			r = $urandom_range(0, 99);
			if (r < 12) cmd = CMD_DUMP;
			else if (growing ? r < 50 : r < 20) cmd = CMD_APPEND;
			else if (growing ? r < 88 : r < 30) cmd = CMD_INSERT;
			else cmd = CMD_REMOVE;
			case ($urandom_range(0, 11))
				0:       word = 32'sh7fffffff;
				1:       word = 32'sh80000000;
				2:       word = -32'sd1;
				3:       word = 32'sd0;
				default: word = $urandom;
			endcase
			// Mostly legal positions, with some anywhere in the field.
			if ($urandom_range(0, 4) == 0)
				pos = 5'($urandom_range(0, 31));
			else if (cmd == CMD_INSERT)
				pos = 5'($urandom_range(0, n));
			else
				pos = (n > 0) ? 5'($urandom_range(0, n - 1)) : 5'd0;
			send_item(cmd, word, pos);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		command  <= CMD_APPEND;
		data     <= '0;
		position <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list;
		test_positions;
		test_full_list;
		test_random_traffic;

		// Drop start, drain the outstanding results, then keep the clock
		// running so the block can show anything it should not.
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Hang guard.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
